// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== sv/mse_pkg.sv =====
package mse_pkg;

   typedef enum logic [5:0] {
      ST_LOAD    = 6'b000001,
      ST_START   = 6'b000010,
      ST_SETUP_A = 6'b000100,
      ST_SETUP_B = 6'b001000,
      ST_MERGE   = 6'b010000,
      ST_EMIT    = 6'b100000
   } mse_state_type;

   typedef struct packed {
      logic load;
      logic sort_init;
      logic setup_a;
      logic setup_b;
      logic merge;
      logic emit;
   } mse_cmd_type;

   typedef struct packed {
      logic merge_end;
      logic pass_end;
      logic sort_end;
      logic short_list;
      logic list_sent;
   } mse_status_type;

endpackage

// ===== sv/mse_ram.sv =====
module mse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en_0,
   input  logic [ADDR_W-1:0] rd_addr_0,
   output logic [WIDTH-1:0]  rd_data_0,
   input  logic              rd_en_1,
   input  logic [ADDR_W-1:0] rd_addr_1,
   output logic [WIDTH-1:0]  rd_data_1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_0_ff;
   logic [WIDTH-1:0] rd_data_1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en_0) begin
         rd_data_0_ff <= mem_ff[rd_addr_0];
      end
      if (rd_en_1) begin
         rd_data_1_ff <= mem_ff[rd_addr_1];
      end
   end

   assign rd_data_0 = rd_data_0_ff;
   assign rd_data_1 = rd_data_1_ff;

endmodule

// ===== sv/mse_ctrl.sv =====
module mse_ctrl import mse_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   input  logic           req_tlast,
   output logic           req_tready,
   input  mse_status_type status,
   output mse_cmd_type    cmd
);

   mse_state_type state_ff;
   mse_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = req_tvalid;
            if (req_tvalid && req_tlast) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.sort_init = 1'b1;
            state_in      = status.short_list ? ST_EMIT : ST_SETUP_A;
         end
         ST_SETUP_A: begin
            cmd.setup_a = 1'b1;
            state_in    = ST_SETUP_B;
         end
         ST_SETUP_B: begin
            cmd.setup_b = 1'b1;
            state_in    = ST_MERGE;
         end
         ST_MERGE: begin
            cmd.merge = 1'b1;
            if (status.merge_end) begin
               state_in = (status.pass_end && status.sort_end) ? ST_EMIT : ST_SETUP_A;
            end
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (status.list_sent) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_LOAD);

endmodule

// ===== sv/mse_dp.sv =====
module mse_dp import mse_pkg::*; #(
   parameter int MAX_LEN = 64,
   parameter int KEY_WIDTH = 32,
   localparam int ADDR_W = $clog2(MAX_LEN),
   localparam int IDX_W = $clog2(MAX_LEN) + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mse_cmd_type          cmd,
   output mse_status_type       status,
   input  logic [KEY_WIDTH-1:0] in_key,
   output logic [KEY_WIDTH-1:0] out_key,
   output logic                 out_valid,
   output logic                 out_last,
   output logic                 out_overflow,
   input  logic                 out_ready
);

   localparam logic [IDX_W-1:0] MaxCount = IDX_W'(MAX_LEN);
   localparam logic [IDX_W-1:0] One = IDX_W'(1);

   logic [IDX_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [IDX_W-1:0] width_ff, width_in;
   logic [IDX_W-1:0] lo_ff, lo_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] hi_ff, hi_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             src_sel_ff, src_sel_in;
   logic [KEY_WIDTH-1:0] a_head_ff, a_head_in;
   logic [KEY_WIDTH-1:0] b_head_ff, b_head_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_ovf_ff, rsp_ovf_in;

   logic [IDX_W-1:0] lo_plus_w, lo_plus_2w, mid_c, hi_c, width_dbl;
   logic [IDX_W-1:0] i_next, j_next, rd_idx_0, rd_idx_1, wr_idx;
   logic             take_left, emit_issue, list_sent;
   logic             rd_en_0, rd_en_1, wr_en_a, wr_en_b;
   logic [KEY_WIDTH-1:0] wr_data;
   logic [KEY_WIDTH-1:0] a_rd_0, a_rd_1, b_rd_0, b_rd_1, src_rd_0, src_rd_1;

   assign lo_plus_w  = lo_ff + width_ff;
   assign lo_plus_2w = lo_plus_w + width_ff;
   assign mid_c      = (lo_plus_w < count_ff) ? lo_plus_w : count_ff;
   assign hi_c       = (lo_plus_2w < count_ff) ? lo_plus_2w : count_ff;
   assign width_dbl  = {width_ff[IDX_W-2:0], 1'b0};

   assign src_rd_0 = src_sel_ff ? b_rd_0 : a_rd_0;
   assign src_rd_1 = src_sel_ff ? b_rd_1 : a_rd_1;

   // left head wins ties, keeps the sort stable
   assign take_left = (j_ff >= hi_ff) ||
                      ((i_ff < mid_ff) && ($signed(a_head_ff) <= $signed(b_head_ff)));
   assign i_next = take_left ? i_ff + One : i_ff;
   assign j_next = take_left ? j_ff : j_ff + One;

   assign emit_issue = cmd.emit && (!rsp_valid_ff || out_ready) && (ptr_ff < count_ff);
   assign list_sent  = rsp_valid_ff && out_ready && rsp_last_ff;

   assign status.merge_end  = (k_ff + One == hi_ff);
   assign status.pass_end   = (hi_ff == count_ff);
   assign status.sort_end   = (width_dbl >= count_ff);
   assign status.short_list = (count_ff <= One);
   assign status.list_sent  = list_sent;

   // while merging, read port 0 runs one entry ahead of the left head, port 1 of the right head
   always_comb begin
      rd_idx_0 = ptr_ff;
      rd_idx_1 = j_next + One;
      if (cmd.setup_a) begin
         rd_idx_0 = lo_ff;
         rd_idx_1 = mid_c;
      end else if (cmd.setup_b) begin
         rd_idx_0 = i_ff + One;
         rd_idx_1 = j_ff + One;
      end else if (cmd.merge) begin
         rd_idx_0 = i_next + One;
      end
   end

   assign rd_en_0 = cmd.setup_a || cmd.setup_b || cmd.merge || emit_issue;
   assign rd_en_1 = cmd.setup_a || cmd.setup_b || cmd.merge;

   assign wr_idx  = cmd.load ? count_ff : k_ff;
   assign wr_data = cmd.load ? in_key : (take_left ? a_head_ff : b_head_ff);
   assign wr_en_a = (cmd.load && (count_ff < MaxCount)) || (cmd.merge && src_sel_ff);
   assign wr_en_b = cmd.merge && !src_sel_ff;

   mse_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (MAX_LEN)
   ) u_buf_a (
      .clock     (clock),
      .wr_en     (wr_en_a),
      .wr_addr   (wr_idx[ADDR_W-1:0]),
      .wr_data   (wr_data),
      .rd_en_0   (rd_en_0),
      .rd_addr_0 (rd_idx_0[ADDR_W-1:0]),
      .rd_data_0 (a_rd_0),
      .rd_en_1   (rd_en_1),
      .rd_addr_1 (rd_idx_1[ADDR_W-1:0]),
      .rd_data_1 (a_rd_1)
   );

   mse_ram #(
      .WIDTH (KEY_WIDTH),
      .DEPTH (MAX_LEN)
   ) u_buf_b (
      .clock     (clock),
      .wr_en     (wr_en_b),
      .wr_addr   (wr_idx[ADDR_W-1:0]),
      .wr_data   (wr_data),
      .rd_en_0   (rd_en_0),
      .rd_addr_0 (rd_idx_0[ADDR_W-1:0]),
      .rd_data_0 (b_rd_0),
      .rd_en_1   (rd_en_1),
      .rd_addr_1 (rd_idx_1[ADDR_W-1:0]),
      .rd_data_1 (b_rd_1)
   );

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      width_in     = width_ff;
      lo_in        = lo_ff;
      mid_in       = mid_ff;
      hi_in        = hi_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      ptr_in       = ptr_ff;
      src_sel_in   = src_sel_ff;
      a_head_in    = a_head_ff;
      b_head_in    = b_head_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (cmd.load) begin
         if (count_ff < MaxCount) begin
            count_in = count_ff + One;
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (cmd.sort_init) begin
         width_in   = One;
         lo_in      = '0;
         src_sel_in = 1'b0;
         ptr_in     = '0;
      end

      if (cmd.setup_a) begin
         mid_in = mid_c;
         hi_in  = hi_c;
         i_in   = lo_ff;
         j_in   = mid_c;
         k_in   = lo_ff;
      end

      if (cmd.setup_b) begin
         a_head_in = src_rd_0;
         b_head_in = src_rd_1;
      end

      if (cmd.merge) begin
         i_in = i_next;
         j_in = j_next;
         k_in = k_ff + One;
         if (take_left) begin
            a_head_in = src_rd_0;
         end else begin
            b_head_in = src_rd_1;
         end
         if (status.merge_end) begin
            lo_in = hi_ff;
            if (status.pass_end) begin
               lo_in      = '0;
               width_in   = width_dbl;
               src_sel_in = !src_sel_ff;
            end
         end
      end

      if (emit_issue) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = (ptr_ff + One == count_ff);
         rsp_ovf_in   = ovf_ff;
         ptr_in       = ptr_ff + One;
      end else if (out_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.emit && list_sent) begin
         count_in = '0;
         ovf_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         ptr_ff       <= '0;
         src_sel_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         ptr_ff       <= ptr_in;
         src_sel_ff   <= src_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      width_ff    <= width_in;
      lo_ff       <= lo_in;
      mid_ff      <= mid_in;
      hi_ff       <= hi_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      a_head_ff   <= a_head_in;
      b_head_ff   <= b_head_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   // buffer read register doubles as the output data register
   assign out_key      = src_rd_0;
   assign out_valid    = rsp_valid_ff;
   assign out_last     = rsp_last_ff;
   assign out_overflow = rsp_ovf_ff;

endmodule

// ===== sv/merge_sort_engine.sv =====
// channel   dir   tdata          tlast         tuser
// req_      in    key            is_last       -
// rsp_      out   sorted_key     end_of_list   overflowed
//
// Load takes one key per cycle. A start step follows, then sorting runs
// ceil(log2 n) passes over two ping-pong buffers; each run pair first primes
// the read-ahead heads in ST_SETUP_A and ST_SETUP_B and is then merged.
// Results then leave at one per cycle while rsp_tready is high; a stall holds
// the buffer read register.
// Reset is synchronous; no input transfer is taken while a list sorts or drains.
`include "assert_macros.svh"

module merge_sort_engine import mse_pkg::*; #(
   parameter int MAX_LEN = 64,
   parameter int KEY_WIDTH = 32,
   localparam int DATA_W = ((KEY_WIDTH + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,   // key
   input  logic              req_tlast,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,   // sorted_key
   output logic              rsp_tlast,
   output logic              rsp_tuser    // overflowed
);

   mse_cmd_type          cmd;
   mse_status_type       status;
   logic [KEY_WIDTH-1:0] out_key;
   logic                 rsp_end;

   mse_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mse_dp #(
      .MAX_LEN   (MAX_LEN),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .in_key       (req_tdata[KEY_WIDTH-1:0]),
      .out_key      (out_key),
      .out_valid    (rsp_tvalid),
      .out_last     (rsp_tlast),
      .out_overflow (rsp_tuser),
      .out_ready    (rsp_tready)
   );

   assign rsp_tdata = DATA_W'(out_key);
   assign rsp_end   = rsp_tvalid && rsp_tready && rsp_tlast;

   `ASSERT_NEVER(a_load_vs_emit, clock, reset, req_tready && rsp_tvalid, "load and emit overlap")
   `ASSERT_NEXT(a_back_to_load, clock, reset, rsp_end, req_tready, "no return to load")
   `ASSERT_NEVER(a_cmd_onehot, clock, reset, !$onehot0(cmd), "several commands at once")
   `ASSERT_IMPLY(a_emit_only, clock, reset, rsp_tvalid, cmd.emit, "result shown outside emit")

endmodule
